[hdl/byte_stuffing_deframer_core_assert.svh]
// assertion macros used by the checker file
`ifndef BYTE_STUFFING_DEFRAMER_CORE_ASSERT_SVH
`define BYTE_STUFFING_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, off while reset is held
`define BSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, also checked across reset
`define BSD_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

[hdl/bsd_pkg.sv]
package bsd_pkg;

    typedef logic [7:0] t_byte;

    // framing and escape codes
    localparam t_byte FLAG_START = 8'hFE;
    localparam t_byte FLAG_END   = 8'hEF;
    localparam t_byte ESC_BYTE   = 8'hFD;
    localparam t_byte ESC_FE     = 8'h01;
    localparam t_byte ESC_FD     = 8'h00;
    localparam t_byte ESC_EF     = 8'hF2;

    // deframer phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_ESC  = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    // frame status codes
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_OK     = 2'd1,
        ST_BADESC = 2'd2,
        ST_NOEND  = 2'd3
    } t_status;

    // one received byte with its buffer end mark
    typedef struct packed {
        t_byte rx_byte;
        logic  buffer_end;
    } t_rx_item;

    // one result item plus a flag telling whether it exists
    typedef struct packed {
        logic    present;
        t_byte   out_byte;
        logic    byte_valid;
        t_status frame_status;
    } t_result;

endpackage

[hdl/bsd_rx_if.sv]
interface bsd_rx_if;
    logic          valid;
    logic          ready;
    bsd_pkg::t_byte rx_byte;
    logic          buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

[hdl/bsd_res_if.sv]
interface bsd_res_if;
    logic           valid;
    logic           ready;
    bsd_pkg::t_byte out_byte;
    logic           byte_valid;
    logic [1:0]     frame_status;

    modport source (output valid, output out_byte, output byte_valid, output frame_status,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input frame_status,
                    output ready);
endinterface

[hdl/bsd_in_stage.sv]
module bsd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsd_rx_if.sink            i_rx,
    input  logic              i_advance,
    output logic              o_valid,
    output bsd_pkg::t_rx_item o_item
);

    logic              r_valid;
    bsd_pkg::t_rx_item r_item;
    logic              n_valid;
    logic              take;

    // accept while empty or while the held byte moves on
    assign i_rx.ready = !r_valid || i_advance;
    assign take       = i_rx.valid && i_rx.ready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.rx_byte    <= i_rx.rx_byte;
            r_item.buffer_end <= i_rx.buffer_end;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hdl/bsd_decode.sv]
module bsd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  bsd_pkg::t_rx_item i_item,
    output bsd_pkg::t_result  o_result
);

    bsd_pkg::t_phase  r_phase;
    bsd_pkg::t_phase  n_phase;
    bsd_pkg::t_byte   ob;
    logic             ob_valid;
    bsd_pkg::t_status st;
    logic             last;
    bsd_pkg::t_byte   b;

    assign b    = i_item.rx_byte;
    assign last = i_item.buffer_end;

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bsd_pkg::PH_HUNT;
        end else if (i_fire) begin
            r_phase <= n_phase;
        end
    end

    // next phase and result for the byte held in the input stage
    always_comb begin
        n_phase  = r_phase;
        ob       = '0;
        ob_valid = 1'b0;
        st       = bsd_pkg::ST_NONE;
        case (r_phase)
            bsd_pkg::PH_HUNT: begin
                if (b == bsd_pkg::FLAG_START) begin
                    n_phase = bsd_pkg::PH_DATA;
                end
                if (last) begin
                    st = bsd_pkg::ST_NOEND;
                end
            end
            bsd_pkg::PH_DATA: begin
                if (b == bsd_pkg::FLAG_END) begin
                    st      = bsd_pkg::ST_OK;
                    n_phase = bsd_pkg::PH_SKIP;
                end else if (b == bsd_pkg::ESC_BYTE) begin
                    n_phase = bsd_pkg::PH_ESC;
                    if (last) begin
                        st = bsd_pkg::ST_NOEND;
                    end
                end else begin
                    ob       = b;
                    ob_valid = 1'b1;
                    if (last) begin
                        st = bsd_pkg::ST_NOEND;
                    end
                end
            end
            bsd_pkg::PH_ESC: begin
                n_phase = bsd_pkg::PH_DATA;
                case (b)
                    bsd_pkg::ESC_FE: begin
                        ob       = bsd_pkg::FLAG_START;
                        ob_valid = 1'b1;
                    end
                    bsd_pkg::ESC_FD: begin
                        ob       = bsd_pkg::ESC_BYTE;
                        ob_valid = 1'b1;
                    end
                    bsd_pkg::ESC_EF: begin
                        ob       = bsd_pkg::FLAG_END;
                        ob_valid = 1'b1;
                    end
                    default: begin
                        st      = bsd_pkg::ST_BADESC;
                        n_phase = bsd_pkg::PH_SKIP;
                    end
                endcase
                if (last && ob_valid) begin
                    st = bsd_pkg::ST_NOEND;
                end
            end
            default: begin
                n_phase = bsd_pkg::PH_SKIP;
            end
        endcase
        // every buffer end goes back to hunting
        if (last) begin
            n_phase = bsd_pkg::PH_HUNT;
        end
    end

    assign o_result.present      = ob_valid || (st != bsd_pkg::ST_NONE);
    assign o_result.out_byte     = ob;
    assign o_result.byte_valid   = ob_valid;
    assign o_result.frame_status = st;

endmodule

[hdl/bsd_out_stage.sv]
module bsd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  bsd_pkg::t_result i_result,
    output logic             o_can_load,
    bsd_res_if.source        o_res
);

    logic             r_valid;
    bsd_pkg::t_result r_result;
    logic             n_valid;
    logic             load;

    // the register frees up in the same cycle its result is taken
    assign o_can_load = !r_valid || o_res.ready;
    assign load       = i_fire && i_result.present;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.out_byte     = r_result.out_byte;
    assign o_res.byte_valid   = r_result.byte_valid;
    assign o_res.frame_status = r_result.frame_status;

endmodule

[hdl/byte_stuffing_deframer_core.sv]
// Byte-stuffing deframer.
// i_rx carries one received byte per transfer together with a buffer end mark.
// Bytes are dropped until the start flag, then unstuffed payload bytes flow
// out on o_res until the end flag; escape pairs are decoded on the way.
// o_res carries at most one result per received byte: a payload byte, a
// frame status (ok, bad escape, buffer ended without end flag), or both.
// Bytes that yield nothing (escape bytes and hunted bytes that do not end
// a buffer, skipped bytes) are consumed without any transfer on o_res.
// A taken byte passes two register stages, the input register and then the
// result register, before its result shows on o_res.
// Throughput: one byte per cycle while o_res is not stalled.
// Reset clears both stage valids and returns the phase to hunting.
// When the receiver stalls, the result register holds; one more byte is
// taken into the input register, after which i_rx.ready drops until the
// result is taken.
module byte_stuffing_deframer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsd_rx_if.sink    i_rx,
    bsd_res_if.source o_res
);

    logic              in_valid;
    bsd_pkg::t_rx_item in_item;
    bsd_pkg::t_result  result;
    logic              can_load;
    logic              fire;

    // the held byte is processed once the result register can take it
    assign fire = in_valid && can_load;

    bsd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (fire),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    bsd_decode u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (in_item),
        .o_result (result)
    );

    bsd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_result   (result),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

endmodule

[hdl/bsd_checker.sv]
`include "byte_stuffing_deframer_core_assert.svh"

module bsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic [1:0] i_frame_status
);

    // a result always carries a byte or a status
    `BSD_ASSERT_IMPL(a_nonempty, i_clk, i_rst_n, i_res_valid, i_byte_valid || (i_frame_status != bsd_pkg::ST_NONE))

    // the byte field is zero when no byte is carried
    `BSD_ASSERT_IMPL(a_zero_byte, i_clk, i_rst_n, i_res_valid && !i_byte_valid, i_out_byte == 8'h00)

    // end flag and bad escape never come with a payload byte
    `BSD_ASSERT_IMPL(a_status_no_byte, i_clk, i_rst_n, i_res_valid && (i_frame_status == bsd_pkg::ST_OK || i_frame_status == bsd_pkg::ST_BADESC), !i_byte_valid)

    // a stalled result holds
    `BSD_ASSERT_NEXT(a_hold, i_clk, i_rst_n && $past(i_rst_n) && i_res_valid && !i_res_ready, i_res_valid && $stable(i_out_byte) && $stable(i_byte_valid) && $stable(i_frame_status))

    // nothing is offered right after reset
    `BSD_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !i_res_valid)

endmodule

bind byte_stuffing_deframer_core bsd_checker u_bsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_out_byte     (o_res.out_byte),
    .i_byte_valid   (o_res.byte_valid),
    .i_frame_status (o_res.frame_status)
);

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    // one received byte with its buffer end mark
    typedef bsd_pkg::t_rx_item t_rx_item;

    // one expected transfer on the result channel
    typedef struct {
        bsd_pkg::t_byte   out_byte;
        logic             byte_valid;
        bsd_pkg::t_status frame_status;
    } t_unstuffed;

    // tracks the deframer phase and the results still owed by the block
    class deframe_scoreboard;
        bsd_pkg::t_phase phase = bsd_pkg::PH_HUNT;
        t_unstuffed      unstuffed_q[$];
        int              errors = 0;

        // unstuff one accepted byte and queue what it should produce
        function void note_rx(bsd_pkg::t_byte b, logic last);
            bsd_pkg::t_byte   ob = '0;
            logic             vld = 1'b0;
            bsd_pkg::t_status st = bsd_pkg::ST_NONE;
            bsd_pkg::t_phase  nxt = phase;
            t_unstuffed       res;
            case (phase)
                bsd_pkg::PH_HUNT: begin
                    if (b == bsd_pkg::FLAG_START) nxt = bsd_pkg::PH_DATA;
                    if (last) st = bsd_pkg::ST_NOEND;
                end
                bsd_pkg::PH_DATA: begin
                    if (b == bsd_pkg::FLAG_END) begin
                        st  = bsd_pkg::ST_OK;
                        nxt = bsd_pkg::PH_SKIP;
                    end else if (b == bsd_pkg::ESC_BYTE) begin
                        nxt = bsd_pkg::PH_ESC;
                        if (last) st = bsd_pkg::ST_NOEND;
                    end else begin
                        ob  = b;
                        vld = 1'b1;
                        if (last) st = bsd_pkg::ST_NOEND;
                    end
                end
                bsd_pkg::PH_ESC: begin
                    nxt = bsd_pkg::PH_DATA;
                    case (b)
                        bsd_pkg::ESC_FE: begin ob = bsd_pkg::FLAG_START; vld = 1'b1; end
                        bsd_pkg::ESC_FD: begin ob = bsd_pkg::ESC_BYTE;   vld = 1'b1; end
                        bsd_pkg::ESC_EF: begin ob = bsd_pkg::FLAG_END;   vld = 1'b1; end
                        default: begin
                            st  = bsd_pkg::ST_BADESC;
                            nxt = bsd_pkg::PH_SKIP;
                        end
                    endcase
                    if (last && vld) st = bsd_pkg::ST_NOEND;
                end
                default: nxt = bsd_pkg::PH_SKIP;
            endcase
            // any buffer end goes back to hunting
            if (last) nxt = bsd_pkg::PH_HUNT;
            phase = nxt;
            if (vld || st != bsd_pkg::ST_NONE) begin
                res.out_byte     = ob;
                res.byte_valid   = vld;
                res.frame_status = st;
                unstuffed_q.push_back(res);
            end
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_res(bsd_pkg::t_byte ob, logic bv, logic [1:0] st);
            t_unstuffed exp_res;
            if (unstuffed_q.size() == 0) begin
                $error("unexpected result: out_byte %02h byte_valid %0b frame_status %0d",
                       ob, bv, st);
                errors++;
                return;
            end
            exp_res = unstuffed_q.pop_front();
            if (ob !== exp_res.out_byte) begin
                $error("out_byte: expected %02h, actual %02h", exp_res.out_byte, ob);
                errors++;
            end
            if (bv !== exp_res.byte_valid) begin
                $error("byte_valid: expected %0b, actual %0b", exp_res.byte_valid, bv);
                errors++;
            end
            if (st !== exp_res.frame_status) begin
                $error("frame_status: expected %0d, actual %0d", exp_res.frame_status, st);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bsd_rx_if  rx_bus();
    bsd_res_if res_bus();

    byte_stuffing_deframer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_bus),
        .o_res   (res_bus)
    );

    deframe_scoreboard sb = new;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int hold_off_cycles = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

    // offer one byte, called and returning just after a falling edge
    task automatic send_rx(input bsd_pkg::t_byte b, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            rx_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        rx_bus.valid      = 1'b1;
        rx_bus.rx_byte    = b;
        rx_bus.buffer_end = last;
        do @(posedge i_clk); while (rx_bus.ready !== 1'b1);
        sb.note_rx(b, last);
        @(negedge i_clk);
    endtask

    // result receiver with random stalls and an occasional long hold-off
    initial begin
        int stall;
        res_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                res_bus.ready = 1'b0;
                repeat (hold_off_cycles) @(negedge i_clk);
                hold_off_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                res_bus.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_bus.ready = 1'b1;
            do @(posedge i_clk); while (res_bus.valid !== 1'b1);
            sb.check_res(res_bus.out_byte, res_bus.byte_valid, res_bus.frame_status);
            @(negedge i_clk);
        end
    end

    // stimulus
    initial begin
        t_rx_item       buf_q[$];
        bsd_pkg::t_byte specials[6];
        bsd_pkg::t_byte pb;
        bsd_pkg::t_byte bad_code;
        int             kind;
        int             n;
        int             bad_at;
        int             sent;
        int             target;

        specials = '{bsd_pkg::FLAG_START, bsd_pkg::FLAG_END, bsd_pkg::ESC_BYTE,
                     bsd_pkg::ESC_FE, bsd_pkg::ESC_FD, bsd_pkg::ESC_EF};
        rx_bus.valid      = 1'b0;
        rx_bus.rx_byte    = '0;
        rx_bus.buffer_end = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // start flag as the last byte of a buffer while hunting
        send_rx(bsd_pkg::FLAG_START, 1'b1);
        // frame with every escape pair, a raw start flag, then skipped bytes
        send_rx(bsd_pkg::FLAG_START, 1'b0);
        send_rx(8'hFF, 1'b0);
        send_rx(bsd_pkg::ESC_BYTE, 1'b0);
        send_rx(bsd_pkg::ESC_FE, 1'b0);
        send_rx(bsd_pkg::ESC_BYTE, 1'b0);
        send_rx(bsd_pkg::ESC_FD, 1'b0);
        send_rx(bsd_pkg::ESC_BYTE, 1'b0);
        send_rx(bsd_pkg::ESC_EF, 1'b0);
        send_rx(bsd_pkg::FLAG_START, 1'b0);
        send_rx(bsd_pkg::FLAG_END, 1'b0);
        send_rx(8'hAA, 1'b1);
        // buffer ends on a data byte
        send_rx(bsd_pkg::FLAG_START, 1'b0);
        send_rx(8'h00, 1'b1);
        // buffer ends on a good escape code
        send_rx(bsd_pkg::FLAG_START, 1'b0);
        send_rx(bsd_pkg::ESC_BYTE, 1'b0);
        send_rx(bsd_pkg::ESC_FE, 1'b1);
        // buffer ends on the escape byte
        send_rx(bsd_pkg::FLAG_START, 1'b0);
        send_rx(bsd_pkg::ESC_BYTE, 1'b1);
        // end flag used as escape code, rest of buffer ignored
        send_rx(bsd_pkg::FLAG_START, 1'b0);
        send_rx(bsd_pkg::ESC_BYTE, 1'b0);
        send_rx(bsd_pkg::FLAG_END, 1'b0);
        send_rx(8'h55, 1'b1);
        // bad escape code on the last byte
        send_rx(bsd_pkg::FLAG_START, 1'b0);
        send_rx(bsd_pkg::ESC_BYTE, 1'b0);
        send_rx(8'h77, 1'b1);
        // end flag on the last byte
        send_rx(bsd_pkg::FLAG_START, 1'b0);
        send_rx(bsd_pkg::FLAG_END, 1'b1);

        // random buffers, four quarters with different idling
        sent = 0;
        for (int quarter = 0; quarter < 4; quarter++) begin
            tx_idle = (quarter == 0 || quarter == 2);
            rx_idle = (quarter == 0 || quarter == 3);
            // long receiver hold-off while the sender keeps offering
            if (quarter == 1) hold_off_cycles = 80;
            target = 2000 * (quarter + 1) / 4;
            while (sent < target) begin
                buf_q.delete();
                kind = $urandom_range(0, 9);
                // line noise before the start flag
                repeat ($urandom_range(0, 2))
                    buf_q.push_back(t_rx_item'{bsd_pkg::t_byte'($urandom), 1'b0});
                if (kind == 9) begin
                    // pure noise buffer
                    repeat ($urandom_range(1, 6))
                        buf_q.push_back(t_rx_item'{bsd_pkg::t_byte'($urandom), 1'b0});
                end else begin
                    buf_q.push_back(t_rx_item'{bsd_pkg::FLAG_START, 1'b0});
                    n = $urandom_range(0, 12);
                    bad_at = (kind == 8) ? $urandom_range(0, n) : -1;
                    for (int i = 0; i <= n; i++) begin
                        if (i == bad_at) begin
                            bad_code = bsd_pkg::t_byte'($urandom);
                            if (bad_code == bsd_pkg::ESC_FE || bad_code == bsd_pkg::ESC_FD ||
                                bad_code == bsd_pkg::ESC_EF)
                                bad_code = bsd_pkg::FLAG_END;
                            buf_q.push_back(t_rx_item'{bsd_pkg::ESC_BYTE, 1'b0});
                            buf_q.push_back(t_rx_item'{bad_code, 1'b0});
                        end
                        if (i < n) begin
                            pb = ($urandom_range(0, 3) == 0) ? specials[$urandom_range(0, 5)]
                                                             : bsd_pkg::t_byte'($urandom);
                            // stuff reserved codes, a raw start flag is still data
                            case (pb)
                                bsd_pkg::FLAG_START: begin
                                    if ($urandom_range(0, 1)) begin
                                        buf_q.push_back(t_rx_item'{bsd_pkg::ESC_BYTE, 1'b0});
                                        buf_q.push_back(t_rx_item'{bsd_pkg::ESC_FE, 1'b0});
                                    end else begin
                                        buf_q.push_back(t_rx_item'{bsd_pkg::FLAG_START, 1'b0});
                                    end
                                end
                                bsd_pkg::ESC_BYTE: begin
                                    buf_q.push_back(t_rx_item'{bsd_pkg::ESC_BYTE, 1'b0});
                                    buf_q.push_back(t_rx_item'{bsd_pkg::ESC_FD, 1'b0});
                                end
                                bsd_pkg::FLAG_END: begin
                                    buf_q.push_back(t_rx_item'{bsd_pkg::ESC_BYTE, 1'b0});
                                    buf_q.push_back(t_rx_item'{bsd_pkg::ESC_EF, 1'b0});
                                end
                                default: buf_q.push_back(t_rx_item'{pb, 1'b0});
                            endcase
                        end
                    end
                    if (kind == 7) begin
                        // truncated frame, sometimes cut right after an escape byte
                        if ($urandom_range(0, 1))
                            buf_q.push_back(t_rx_item'{bsd_pkg::ESC_BYTE, 1'b0});
                    end else begin
                        buf_q.push_back(t_rx_item'{bsd_pkg::FLAG_END, 1'b0});
                        repeat ($urandom_range(0, 2))
                            buf_q.push_back(t_rx_item'{bsd_pkg::t_byte'($urandom), 1'b0});
                    end
                end
                buf_q[buf_q.size() - 1].buffer_end = 1'b1;
                sent += buf_q.size();
                foreach (buf_q[i]) send_rx(buf_q[i].rx_byte, buf_q[i].buffer_end);
            end
        end
        rx_bus.valid = 1'b0;

        // drain, then give a stray result time to show up
        while (sb.unstuffed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
